// ===== rtl/slbc_pkg.sv =====
// ----------------------------------------------------------------------------
// slbc_pkg
// Shared types and constants of the status LED blink controller.
// ----------------------------------------------------------------------------
`default_nettype none

package slbc_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int LED_COUNT   = 2;

    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);
    localparam int QUEUE_SW = QUEUE_AW + 1;
    localparam int LED_W    = $clog2(LED_COUNT);

    localparam int OBUF_DEPTH = 4;
    localparam int OBUF_AW    = $clog2(OBUF_DEPTH);
    localparam int OBUF_CW    = $clog2(OBUF_DEPTH + 1);

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [15:0] ATTN_RESET = 16'd1000;

    typedef enum logic [2:0] {
        KIND_TICK    = 3'd0,
        KIND_BATTERY = 3'd1,
        KIND_POWER   = 3'd2,
        KIND_PROFILE = 3'd3,
        KIND_LINK    = 3'd4
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROLE_PERIPHERAL = 3'd0,
        CFG_USB_PRESENT     = 3'd1,
        CFG_BRIGHTNESS      = 3'd2,
        CFG_BATT_LOW_PCT    = 3'd3,
        CFG_BATT_FULL_PCT   = 3'd4,
        CFG_ATTN_INTERVAL   = 3'd5,
        CFG_SLOW_ON_MS      = 3'd6,
        CFG_EVENT_ON_MS     = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        COLOUR_RED   = 2'd0,
        COLOUR_GREEN = 2'd1,
        COLOUR_BLUE  = 2'd2
    } t_colour;

    // queue entry, led in bit 0
    typedef struct packed {
        logic             event_blink;
        logic [1:0]       colour;
        logic [LED_W-1:0] led;
    } t_blink;

    // pixel update, led in bit 0
    typedef struct packed {
        logic             last;
        logic [7:0]       blue;
        logic [7:0]       green;
        logic [7:0]       red;
        logic [LED_W-1:0] led;
    } t_pixel;

    function automatic logic [1:0] profile_colour(input logic [3:0] idx);
        logic [1:0] c;
        if (idx == 4'd0) begin
            c = COLOUR_GREEN;
        end else if (idx == 4'd1) begin
            c = COLOUR_RED;
        end else begin
            c = COLOUR_BLUE;
        end
        return c;
    endfunction

    function automatic logic [QUEUE_AW-1:0] queue_wrap(input logic [QUEUE_SW-1:0] s);
        logic [QUEUE_SW-1:0] r;
        if (s >= QUEUE_SW'(QUEUE_DEPTH)) begin
            r = s - QUEUE_SW'(QUEUE_DEPTH);
        end else begin
            r = s;
        end
        return r[QUEUE_AW-1:0];
    endfunction

    function automatic t_pixel make_pixel(input logic [LED_W-1:0] led,
                                          input logic [1:0] colour,
                                          input logic lit,
                                          input logic [7:0] level);
        t_pixel p;
        p.led   = led;
        p.red   = (lit && colour == COLOUR_RED)   ? level : 8'd0;
        p.green = (lit && colour == COLOUR_GREEN) ? level : 8'd0;
        p.blue  = (lit && colour == COLOUR_BLUE)  ? level : 8'd0;
        p.last  = 1'b0;
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/status_led_blink_controller.sv =====
// ----------------------------------------------------------------------------
// status_led_blink_controller
// Two-LED status indicator: status flags, attention timer and blink queue,
// producing pixel updates on millisecond ticks.
// ----------------------------------------------------------------------------
// One event transfer per cycle; its state update is done in the cycle of the
// transfer and its pixel updates (up to two) enter a four-entry output buffer.
// Pixel updates are registered in the buffer; one event is taken per cycle
// while it holds two entries or fewer, and one update drains per cycle while
// m_axis_tready is high. Synchronous active-low reset clears flags, the blink
// timer and the queue and buffer pointers, and presets the attention timer.
`default_nettype none

module status_led_blink_controller
    import slbc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // charge_pct, usb_powered, profile_index, profile_connected,
    // profile_open, link_connected
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // kind
    input  wire logic [S_TUSER_W-1:0] s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // led_index, red, green, blue
    output logic [M_TDATA_W-1:0]      m_axis_tdata,
    output logic                      m_axis_tlast
);

    // configuration
    logic        r_role;
    logic        r_usb_present;
    logic [7:0]  r_brightness;
    logic [6:0]  r_low_pct;
    logic [6:0]  r_full_pct;
    logic [15:0] r_interval;
    logic [15:0] r_slow_on;
    logic [15:0] r_event_on;

    // status
    logic        r_batt_low, n_batt_low;
    logic        r_batt_full, n_batt_full;
    logic        r_powered, n_powered;
    logic [3:0]  r_profile, n_profile;
    logic        r_radio_conn, n_radio_conn;
    logic        r_radio_search, n_radio_search;
    logic        r_link_up, n_link_up;
    logic [15:0] r_attn, n_attn;

    // blink queue and current blink
    t_blink                r_queue [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_head, n_head;
    logic [QUEUE_CW-1:0]   r_qcount, n_qcount;
    logic                  r_active, n_active;
    logic [LED_W-1:0]      r_blink_led, n_blink_led;
    logic [15:0]           r_remain, n_remain;

    // output buffer
    t_pixel                r_obuf [OBUF_DEPTH];
    logic [OBUF_AW-1:0]    r_wr_ptr;
    logic [OBUF_AW-1:0]    r_rd_ptr;
    logic [OBUF_CW-1:0]    r_ocount;

    // decoded event
    logic        accept;
    t_kind       kind;
    logic [6:0]  charge;
    logic        usb_in;
    logic [3:0]  pidx;
    logic        pconn;
    logic        popen;
    logic        lconn;
    logic [LED_W-1:0] batt_led;

    // enqueue candidates
    t_blink      cand0, cand1, put0, put1;
    logic        cv0, cv1;
    logic        wr0, wr1;
    logic [QUEUE_AW-1:0] wa0, wa1;
    logic [QUEUE_CW-1:0] qcount_mid;
    logic        full_now;
    t_blink      deq;
    logic [15:0] dur;

    // pixel updates
    t_pixel      pix0, pix1, push0, push1;
    logic        pv0, pv1;
    logic        do_push0, do_push1;
    logic        pop;

    assign s_axis_tready = (r_ocount <= OBUF_CW'(OBUF_DEPTH - 2));
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign kind     = t_kind'(s_axis_tuser);
    assign charge   = s_axis_tdata[6:0];
    assign usb_in   = s_axis_tdata[7];
    assign pidx     = s_axis_tdata[11:8];
    assign pconn    = s_axis_tdata[12];
    assign popen    = s_axis_tdata[13];
    assign lconn    = s_axis_tdata[14];
    assign batt_led = r_role ? LED_W'(0) : LED_W'(1);

    always_comb begin
        n_batt_low     = r_batt_low;
        n_batt_full    = r_batt_full;
        n_powered      = r_powered;
        n_profile      = r_profile;
        n_radio_conn   = r_radio_conn;
        n_radio_search = r_radio_search;
        n_link_up      = r_link_up;
        n_attn         = r_attn;
        cand0          = '0;
        cand1          = '0;
        cv0            = 1'b0;
        cv1            = 1'b0;
        full_now       = 1'b0;

        unique case (kind)
            KIND_TICK: begin
                if (r_attn <= 16'd1) begin
                    n_attn = r_interval;
                    if (!r_role) begin
                        cand0 = '{event_blink: 1'b0, colour: profile_colour(r_profile),
                                  led: LED_W'(0)};
                        cv0   = r_radio_search && !r_radio_conn;
                        if (!r_link_up) begin
                            cand1 = '{event_blink: 1'b0, colour: COLOUR_BLUE, led: LED_W'(1)};
                            cv1   = 1'b1;
                        end else if (r_usb_present && r_powered) begin
                            cand1 = '{event_blink: 1'b0, colour: COLOUR_GREEN, led: LED_W'(1)};
                            cv1   = !r_batt_full;
                        end else begin
                            cand1 = '{event_blink: 1'b0, colour: COLOUR_RED, led: LED_W'(1)};
                            cv1   = r_batt_low;
                        end
                    end else begin
                        if (r_usb_present && r_powered) begin
                            cand0 = '{event_blink: 1'b0, colour: COLOUR_GREEN, led: LED_W'(0)};
                            cv0   = !r_batt_full;
                        end else begin
                            cand0 = '{event_blink: 1'b0, colour: COLOUR_RED, led: LED_W'(0)};
                            cv0   = r_batt_low;
                        end
                        cand1 = '{event_blink: 1'b0, colour: COLOUR_BLUE, led: LED_W'(1)};
                        cv1   = !r_link_up;
                    end
                end else begin
                    n_attn = r_attn - 16'd1;
                end
            end
            KIND_BATTERY: begin
                n_batt_low = (charge <= r_low_pct);
                if (r_usb_present) begin
                    full_now    = (charge >= r_full_pct);
                    cand0       = '{event_blink: 1'b1, colour: COLOUR_GREEN, led: batt_led};
                    cv0         = r_powered && full_now && !r_batt_full;
                    n_batt_full = full_now;
                end
            end
            KIND_POWER: begin
                if (r_usb_present) begin
                    cand0     = '{event_blink: 1'b1, colour: COLOUR_GREEN, led: batt_led};
                    cv0       = usb_in && !r_powered && r_batt_full;
                    n_powered = usb_in;
                    n_attn    = 16'd0;
                end
            end
            KIND_PROFILE: begin
                if (!r_role) begin
                    n_profile      = pidx;
                    n_radio_conn   = pconn;
                    n_radio_search = popen;
                    cand0          = '{event_blink: 1'b1, colour: profile_colour(pidx),
                                       led: LED_W'(0)};
                    cv0            = pconn;
                    n_attn         = 16'd0;
                end
            end
            KIND_LINK: begin
                n_link_up = lconn;
                cand0     = '{event_blink: 1'b1, colour: COLOUR_BLUE, led: LED_W'(1)};
                cv0       = lconn;
                n_attn    = 16'd0;
            end
            default: begin
            end
        endcase
    end

    // queue writes: compact candidates, drop when full
    always_comb begin
        put0       = cv0 ? cand0 : cand1;
        put1       = cand1;
        wr0        = (cv0 || cv1) && (r_qcount < QUEUE_CW'(QUEUE_DEPTH));
        wr1        = cv0 && cv1 && ((r_qcount + QUEUE_CW'(1)) < QUEUE_CW'(QUEUE_DEPTH));
        wa0        = queue_wrap(QUEUE_SW'(r_head) + QUEUE_SW'(r_qcount));
        wa1        = queue_wrap(QUEUE_SW'(r_head) + QUEUE_SW'(r_qcount) + QUEUE_SW'(1));
        qcount_mid = r_qcount + QUEUE_CW'(wr0) + QUEUE_CW'(wr1);
    end

    // blink step on a tick
    always_comb begin
        n_head      = r_head;
        n_qcount    = qcount_mid;
        n_active    = r_active;
        n_blink_led = r_blink_led;
        n_remain    = r_remain;
        pix0        = make_pixel(r_blink_led, COLOUR_RED, 1'b0, r_brightness);
        pix1        = '0;
        pv0         = 1'b0;
        pv1         = 1'b0;
        deq         = (r_qcount != '0) ? r_queue[r_head] : put0;
        dur         = deq.event_blink ? r_event_on : r_slow_on;

        if (kind == KIND_TICK) begin
            if (r_active) begin
                if (r_remain <= 16'd1) begin
                    pv0      = 1'b1;
                    n_active = 1'b0;
                    n_remain = 16'd0;
                end else begin
                    n_remain = r_remain - 16'd1;
                end
            end
            if (!n_active && qcount_mid != '0) begin
                n_head      = queue_wrap(QUEUE_SW'(r_head) + QUEUE_SW'(1));
                n_qcount    = qcount_mid - QUEUE_CW'(1);
                n_blink_led = deq.led;
                n_remain    = (dur == 16'd0) ? 16'd1 : dur;
                n_active    = 1'b1;
                pv1         = 1'b1;
                pix1        = make_pixel(deq.led, deq.colour, 1'b1, r_brightness);
            end
        end

        pix0.last = !pv1;
        pix1.last = 1'b1;
    end

    // output buffer pushes
    always_comb begin
        push0    = pv0 ? pix0 : pix1;
        push1    = pix1;
        do_push0 = accept && (pv0 || pv1);
        do_push1 = accept && pv0 && pv1;
        pop      = m_axis_tvalid && m_axis_tready;
    end

    assign m_axis_tvalid = (r_ocount != '0);
    assign m_axis_tdata  = {{(M_TDATA_W - 25){1'b0}}, r_obuf[r_rd_ptr][24:0]};
    assign m_axis_tlast  = r_obuf[r_rd_ptr].last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_role        <= 1'b0;
            r_usb_present <= 1'b1;
            r_brightness  <= 8'd64;
            r_low_pct     <= 7'd20;
            r_full_pct    <= 7'd100;
            r_interval    <= 16'd2000;
            r_slow_on     <= 16'd200;
            r_event_on    <= 16'd400;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ROLE_PERIPHERAL: r_role        <= i_cfg_data[0];
                CFG_USB_PRESENT:     r_usb_present <= i_cfg_data[0];
                CFG_BRIGHTNESS:      r_brightness  <= i_cfg_data[7:0];
                CFG_BATT_LOW_PCT:    r_low_pct     <= i_cfg_data[6:0];
                CFG_BATT_FULL_PCT:   r_full_pct    <= i_cfg_data[6:0];
                CFG_ATTN_INTERVAL:   r_interval    <= i_cfg_data;
                CFG_SLOW_ON_MS:      r_slow_on     <= i_cfg_data;
                CFG_EVENT_ON_MS:     r_event_on    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batt_low     <= 1'b0;
            r_batt_full    <= 1'b0;
            r_powered      <= 1'b0;
            r_profile      <= 4'd0;
            r_radio_conn   <= 1'b0;
            r_radio_search <= 1'b0;
            r_link_up      <= 1'b0;
            r_attn         <= ATTN_RESET;
            r_head         <= '0;
            r_qcount       <= '0;
            r_active       <= 1'b0;
            r_blink_led    <= '0;
            r_remain       <= 16'd0;
        end else if (accept) begin
            r_batt_low     <= n_batt_low;
            r_batt_full    <= n_batt_full;
            r_powered      <= n_powered;
            r_profile      <= n_profile;
            r_radio_conn   <= n_radio_conn;
            r_radio_search <= n_radio_search;
            r_link_up      <= n_link_up;
            r_attn         <= n_attn;
            r_head         <= n_head;
            r_qcount       <= n_qcount;
            r_active       <= n_active;
            r_blink_led    <= n_blink_led;
            r_remain       <= n_remain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && wr0) begin
            r_queue[wa0] <= put0;
        end
        if (accept && wr1) begin
            r_queue[wa1] <= put1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push0) begin
            r_obuf[r_wr_ptr] <= push0;
        end
        if (do_push1) begin
            r_obuf[r_wr_ptr + OBUF_AW'(1)] <= push1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_ocount <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + OBUF_AW'(do_push0) + OBUF_AW'(do_push1);
            r_rd_ptr <= r_rd_ptr + OBUF_AW'(pop);
            r_ocount <= r_ocount + OBUF_CW'(do_push0) + OBUF_CW'(do_push1)
                        - OBUF_CW'(pop);
        end
    end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the status LED blink controller. Event transfers
// are fed to a cycle-free model of the flags, the attention timer and
// the blink queue. Each pixel update on the output stream is compared with
// the oldest predicted update. The run covers a directed opening and random
// events under several register settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
    import slbc_pkg::*;

    localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [2:0] KIND_SPARE_MID   = 3'd6;
    localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;
    localparam int         SETTLE_CYCLES    = 8;
    localparam int         LIMIT_CYCLES     = 600000;
    // event word: kind in the low bits, then the tdata fields
    localparam int         EVENT_W          = S_TDATA_W + S_TUSER_W;

    class led_scoreboard;
        logic        role_periph;
        logic        usb_on;
        logic [7:0]  level;
        logic [6:0]  low_pct;
        logic [6:0]  full_pct;
        logic [15:0] interval;
        logic [15:0] slow_ms;
        logic [15:0] event_ms;

        logic        batt_low;
        logic        batt_full;
        logic        on_power;
        logic [3:0]  prof;
        logic        prof_conn;
        logic        prof_search;
        logic        link_ok;
        logic [15:0] countdown;
        logic        lit;
        logic        lit_led;
        logic [15:0] remaining;
        t_blink      blinks [QUEUE_DEPTH];
        int          head;
        int          count;

        t_pixel      pending_pixels [$];
        int          errors;

        function new();
            role_periph = 1'b0;
            usb_on      = 1'b1;
            level       = 8'd64;
            low_pct     = 7'd20;
            full_pct    = 7'd100;
            interval    = 16'd2000;
            slow_ms     = 16'd200;
            event_ms    = 16'd400;
            batt_low    = 1'b0;
            batt_full   = 1'b0;
            on_power    = 1'b0;
            prof        = 4'd0;
            prof_conn   = 1'b0;
            prof_search = 1'b0;
            link_ok     = 1'b0;
            countdown   = ATTN_RESET;
            lit         = 1'b0;
            lit_led     = 1'b0;
            remaining   = 16'd0;
            head        = 0;
            count       = 0;
            errors      = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [15:0] v);
            case (idx)
                CFG_ROLE_PERIPHERAL: role_periph = v[0];
                CFG_USB_PRESENT:     usb_on      = v[0];
                CFG_BRIGHTNESS:      level       = v[7:0];
                CFG_BATT_LOW_PCT:    low_pct     = v[6:0];
                CFG_BATT_FULL_PCT:   full_pct    = v[6:0];
                CFG_ATTN_INTERVAL:   interval    = v;
                CFG_SLOW_ON_MS:      slow_ms     = v;
                CFG_EVENT_ON_MS:     event_ms    = v;
                default: ;
            endcase
        endfunction

        function logic [1:0] colour_of(logic [3:0] idx);
            if (idx == 4'd0) begin
                return COLOUR_GREEN;
            end
            if (idx == 4'd1) begin
                return COLOUR_RED;
            end
            return COLOUR_BLUE;
        endfunction

        // a full queue drops the new blink
        function void push_blink(logic led, logic [1:0] colour, logic evt);
            t_blink b;
            if (count >= QUEUE_DEPTH) begin
                return;
            end
            b.led         = led;
            b.colour      = colour;
            b.event_blink = evt;
            blinks[(head + count) % QUEUE_DEPTH] = b;
            count++;
        endfunction

        function void attention();
            if (!role_periph) begin
                if (prof_search && !prof_conn) begin
                    push_blink(1'b0, colour_of(prof), 1'b0);
                end
                if (!link_ok) begin
                    push_blink(1'b1, COLOUR_BLUE, 1'b0);
                end else if (usb_on && on_power) begin
                    if (!batt_full) begin
                        push_blink(1'b1, COLOUR_GREEN, 1'b0);
                    end
                end else if (batt_low) begin
                    push_blink(1'b1, COLOUR_RED, 1'b0);
                end
            end else begin
                if (usb_on && on_power) begin
                    if (!batt_full) begin
                        push_blink(1'b0, COLOUR_GREEN, 1'b0);
                    end
                end else if (batt_low) begin
                    push_blink(1'b0, COLOUR_RED, 1'b0);
                end
                if (!link_ok) begin
                    push_blink(1'b1, COLOUR_BLUE, 1'b0);
                end
            end
        endfunction

        function t_pixel pixel_for(logic led, logic [1:0] colour, logic on);
            t_pixel p;
            p.led   = led;
            p.red   = (on && colour == COLOUR_RED)   ? level : 8'd0;
            p.green = (on && colour == COLOUR_GREEN) ? level : 8'd0;
            p.blue  = (on && colour == COLOUR_BLUE)  ? level : 8'd0;
            p.last  = 1'b0;
            return p;
        endfunction

        // events that leave every flag, timer and queue untouched
        function bit has_effect(logic [EVENT_W-1:0] d);
            logic [2:0] kind;
            kind = d[2:0];
            if (kind > KIND_LINK) begin
                return 1'b0;
            end
            if (kind == KIND_POWER && !usb_on) begin
                return 1'b0;
            end
            if (kind == KIND_PROFILE && role_periph) begin
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_event(logic [EVENT_W-1:0] d);
            logic [2:0]  kind;
            logic [6:0]  charge;
            logic        usb_in;
            logic [3:0]  pidx;
            logic        pconn;
            logic        popen;
            logic        lconn;
            logic        batt_led;
            logic        full;
            logic [15:0] dur;
            t_blink      e;
            t_pixel      upd [$];
            kind     = d[2:0];
            charge   = d[9:3];
            usb_in   = d[10];
            pidx     = d[14:11];
            pconn    = d[15];
            popen    = d[16];
            lconn    = d[17];
            batt_led = !role_periph;
            case (kind)
                KIND_TICK: begin
                    if (countdown <= 16'd1) begin
                        attention();
                        countdown = interval;
                    end else begin
                        countdown--;
                    end
                    if (lit) begin
                        if (remaining <= 16'd1) begin
                            upd.push_back(pixel_for(lit_led, COLOUR_RED, 1'b0));
                            lit       = 1'b0;
                            remaining = 16'd0;
                        end else begin
                            remaining--;
                        end
                    end
                    if (!lit && count > 0) begin
                        e       = blinks[head];
                        head    = (head + 1) % QUEUE_DEPTH;
                        count--;
                        lit_led = e.led;
                        dur     = e.event_blink ? event_ms : slow_ms;
                        remaining = (dur == 16'd0) ? 16'd1 : dur;
                        lit     = 1'b1;
                        upd.push_back(pixel_for(e.led, e.colour, 1'b1));
                    end
                    if (upd.size() > 0) begin
                        upd[upd.size() - 1].last = 1'b1;
                    end
                    foreach (upd[i]) begin
                        pending_pixels.push_back(upd[i]);
                    end
                end
                KIND_BATTERY: begin
                    batt_low = (charge <= low_pct);
                    if (usb_on) begin
                        full = (charge >= full_pct);
                        if (on_power && full && !batt_full) begin
                            push_blink(batt_led, COLOUR_GREEN, 1'b1);
                        end
                        batt_full = full;
                    end
                end
                KIND_POWER: begin
                    if (usb_on) begin
                        if (usb_in && !on_power && batt_full) begin
                            push_blink(batt_led, COLOUR_GREEN, 1'b1);
                        end
                        on_power  = usb_in;
                        countdown = 16'd0;
                    end
                end
                KIND_PROFILE: begin
                    if (!role_periph) begin
                        prof        = pidx;
                        prof_conn   = pconn;
                        prof_search = popen;
                        if (pconn) begin
                            push_blink(1'b0, colour_of(pidx), 1'b1);
                        end
                        countdown = 16'd0;
                    end
                end
                KIND_LINK: begin
                    link_ok = lconn;
                    if (lconn) begin
                        push_blink(1'b1, COLOUR_BLUE, 1'b1);
                    end
                    countdown = 16'd0;
                end
                default: ;
            endcase
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_update(logic [M_TDATA_W-1:0] d, logic tl);
            t_pixel got;
            t_pixel want;
            got = t_pixel'({tl, d[24:0]});
            if (pending_pixels.size() == 0) begin
                report($sformatf("pixel update with none predicted: %h last %b", d, tl));
                return;
            end
            want = pending_pixels.pop_front();
            if (got.led !== want.led) begin
                report($sformatf("led %b, predicted %b", got.led, want.led));
            end
            if (got.red !== want.red) begin
                report($sformatf("red %0d, predicted %0d", got.red, want.red));
            end
            if (got.green !== want.green) begin
                report($sformatf("green %0d, predicted %0d", got.green, want.green));
            end
            if (got.blue !== want.blue) begin
                report($sformatf("blue %0d, predicted %0d", got.blue, want.blue));
            end
            if (got.last !== want.last) begin
                report($sformatf("last %b, predicted %b", got.last, want.last));
            end
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // charge_pct, usb_powered, profile_index, profile_connected,
    // profile_open, link_connected
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    // kind
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // led_index, red, green, blue
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;

    led_scoreboard sb;
    bit            calm = 1'b0;

    status_led_blink_controller DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(8 * LIMIT_CYCLES);
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            sb.note_event({s_axis_tdata, s_axis_tuser});
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_update(m_axis_tdata, m_axis_tlast);
        end
    end

    // output side: random stall before each transfer
    initial begin
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) begin
            @(posedge i_clk);
        end
        forever begin
            stall = calm ? 0 : int'($urandom_range(0, 9));
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    function automatic logic [EVENT_W-1:0] event_word(logic [2:0] kind, logic [6:0] charge,
                                                      logic usb, logic [3:0] pidx,
                                                      logic pconn, logic popen, logic lconn);
        return {1'b0, lconn, popen, pconn, pidx, usb, charge, kind};
    endfunction

    function automatic logic [EVENT_W-1:0] random_event();
        int         pick;
        logic [2:0] kind;
        logic [6:0] charge;
        logic [3:0] pidx;
        pick = $urandom_range(0, 99);
        if (pick < 58) begin
            kind = KIND_TICK;
        end else if (pick < 70) begin
            kind = KIND_BATTERY;
        end else if (pick < 78) begin
            kind = KIND_POWER;
        end else if (pick < 88) begin
            kind = KIND_PROFILE;
        end else if (pick < 97) begin
            kind = KIND_LINK;
        end else begin
            kind = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
        end
        // charge near the thresholds three quarters of the time
        case ($urandom_range(0, 3))
            0: charge = sb.low_pct;
            1: charge = sb.full_pct;
            2: charge = (sb.low_pct < 7'd100) ? sb.low_pct + 7'd1 : 7'd100;
            default: charge = 7'($urandom_range(0, 100));
        endcase
        pidx = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 1))
                                           : 4'($urandom_range(0, 15));
        return event_word(kind, charge, 1'($urandom_range(0, 1)), pidx,
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
    endfunction

    task automatic send_event(logic [EVENT_W-1:0] d);
        int gap;
        gap = calm ? 0 : int'($urandom_range(0, 9));
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= d[S_TUSER_W-1:0];
        s_axis_tdata  <= d[EVENT_W-1:S_TUSER_W];
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(logic role, logic usb, logic [7:0] bright, logic [6:0] low,
                              logic [6:0] full, logic [15:0] intv, logic [15:0] slow,
                              logic [15:0] evt);
        logic [15:0] vals [8];
        t_cfg_idx    idx;
        vals = '{{15'd0, role}, {15'd0, usb}, {8'd0, bright}, {9'd0, low},
                 {9'd0, full}, intv, slow, evt};
        for (int i = 0; i < 8; i++) begin
            idx = t_cfg_idx'(i);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= vals[i];
            sb.set_reg(idx, vals[i]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_random(int n);
        logic [EVENT_W-1:0] d;
        int                 done;
        bit                 counted;
        done = 0;
        while (done < n) begin
            d       = random_event();
            counted = sb.has_effect(d);
            send_event(d);
            if (counted) begin
                done++;
                if (done == n / 2 || $urandom_range(0, 149) == 0) begin
                    wait_drained();
                end
            end
        end
        wait_drained();
    endtask

    initial begin
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed opening under the reset register values
        send_event(event_word(KIND_TICK, 7'd0, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0));
        send_event(event_word(KIND_LINK, 7'd0, 1'b0, 4'd0, 1'b0, 1'b0, 1'b1));
        send_event(event_word(KIND_TICK, 7'd0, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0));
        send_event(event_word(KIND_PROFILE, 7'd0, 1'b0, 4'd0, 1'b1, 1'b0, 1'b0));
        send_event(event_word(KIND_PROFILE, 7'd0, 1'b0, 4'd1, 1'b0, 1'b1, 1'b0));
        send_event(event_word(KIND_PROFILE, 7'd0, 1'b0, 4'd15, 1'b1, 1'b1, 1'b0));
        send_event(event_word(KIND_PROFILE, 7'd0, 1'b0, 4'd2, 1'b1, 1'b0, 1'b0));
        send_event(event_word(KIND_POWER, 7'd0, 1'b1, 4'd0, 1'b0, 1'b0, 1'b0));
        send_event(event_word(KIND_BATTERY, 7'd100, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0));
        send_event(event_word(KIND_BATTERY, 7'd0, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0));
        send_event(event_word(KIND_POWER, 7'd0, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0));
        send_event(event_word(KIND_BATTERY, 7'd100, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0));
        send_event(event_word(KIND_POWER, 7'd0, 1'b1, 4'd0, 1'b0, 1'b0, 1'b0));
        send_event(event_word(KIND_LINK, 7'd0, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0));
        send_event(event_word(KIND_SPARE_FIRST, 7'd127, 1'b1, 4'd15, 1'b1, 1'b1, 1'b1));
        send_event(event_word(KIND_SPARE_MID, 7'd64, 1'b0, 4'd8, 1'b1, 1'b0, 1'b1));
        send_event(event_word(KIND_SPARE_LAST, 7'd0, 1'b1, 4'd0, 1'b0, 1'b1, 1'b0));
        // more blinks than the queue holds
        repeat (4) begin
            send_event(event_word(KIND_LINK, 7'd0, 1'b0, 4'd0, 1'b0, 1'b0, 1'b1));
        end
        send_event(event_word(KIND_TICK, 7'd0, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0));
        send_event(event_word(KIND_TICK, 7'd0, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0));
        send_event(event_word(KIND_BATTERY, 7'd64, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0));
        send_event(event_word(KIND_TICK, 7'd0, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0));
        wait_drained();

        write_regs(1'b0, 1'b1, 8'd255, 7'd20, 7'd100, 16'd6, 16'd3, 16'd5);
        run_random(350);

        // lit times and interval of 1 with no idling, then of zero
        calm = 1'b1;
        write_regs(1'b1, 1'b1, 8'd0, 7'd0, 7'd0, 16'd1, 16'd1, 16'd1);
        run_random(200);
        calm = 1'b0;
        write_regs(1'b0, 1'b0, 8'd1, 7'd100, 7'd100, 16'd0, 16'd0, 16'd0);
        run_random(200);

        // longest timings, the queue only drains on blink starts
        write_regs(1'b1, 1'b0, 8'd128, 7'd50, 7'd60, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(100);

        for (int p = 0; p < 4; p++) begin
            calm = (p == 2);
            write_regs(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       8'($urandom_range(0, 255)), 7'($urandom_range(0, 100)),
                       7'($urandom_range(0, 100)), 16'($urandom_range(1, 12)),
                       16'($urandom_range(1, 6)), 16'($urandom_range(1, 8)));
            run_random(160);
        end
        calm = 1'b0;

        wait_drained();
        repeat (16) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_pixels.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
